/* design/lpb_pkg.sv */
`timescale 1ns / 1ps
package lpb_pkg;

   // Pool size used when the top level is not overridden.
   localparam int NUM_FRAMES_DEF = 16;

   // Frames in use after reset, capped at the configured maximum.
   localparam int FIU_RESET = 16;

   localparam int TABLE_W = 6;
   localparam int PAGE_W  = 32;
   localparam int TRX_W   = 16;
   localparam int CMD_W   = 2;
   localparam int FIDX_W  = 4;
   localparam int FIU_W   = 5;

   // Command codes on the request side.
   localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_APPLY   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NOP     = 2'd3;

   typedef enum logic [1:0] {
      KIND_LOAD,
      KIND_APPLY,
      KIND_RELEASE,
      KIND_IGNORE
   } kind_type;

   // One classified request as it sits in the queue.
   typedef struct packed {
      kind_type               kind;
      logic [TABLE_W-1:0]     tbl_id;
      logic [PAGE_W-1:0]      pg_no;
      logic [TRX_W-1:0]       trx_id;
      logic                   pin;
   } req_entry_type;

   // One result, hit in the lowest bit.
   typedef struct packed {
      logic                   direct_io;
      logic [PAGE_W-1:0]      wb_pg_no;
      logic [TABLE_W-1:0]     wb_tbl_id;
      logic                   writeback_needed;
      logic                   fill_needed;
      logic [FIDX_W-1:0]      frame_index;
      logic                   frame_valid;
      logic                   hit;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_WALK,
      ST_DONE
   } eng_state_type;

endpackage

/* design/lpb_front.sv */
`timescale 1ns / 1ps
module lpb_front
   import lpb_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [55:0]         req_tdata,
   input  logic [CMD_W-1:0]    req_tuser,
   output logic                q_valid,
   output req_entry_type       q_entry,
   input  logic                q_pop
);

   req_entry_type slot_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;
   req_entry_type entry;
   logic          push;

   // Decode the command into a request kind.
   always_comb begin
      entry.tbl_id = req_tdata[5:0];
      entry.pg_no  = req_tdata[37:6];
      entry.trx_id = req_tdata[53:38];
      entry.pin    = req_tdata[54];
      unique case (req_tuser)
         CMD_LOAD:    entry.kind = KIND_LOAD;
         CMD_APPLY:   entry.kind = KIND_APPLY;
         CMD_RELEASE: entry.kind = KIND_RELEASE;
         default:     entry.kind = KIND_IGNORE;
      endcase
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != 2'd0);
   assign q_entry    = slot_ff[rd_ptr_ff];

   // Pointer and fill count of the two-entry queue.
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

/* design/lpb_engine.sv */
`timescale 1ns / 1ps
module lpb_engine
   import lpb_pkg::*;
#(
   parameter int NUM_FRAMES = NUM_FRAMES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   input  logic [FIU_W-1:0]    csr_data,
   input  logic                q_valid,
   input  req_entry_type       q_entry,
   output logic                q_pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output rsp_type             rsp_data
);

   localparam int LW = $clog2(NUM_FRAMES + 1);
   localparam int FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
   localparam logic [LW-1:0] NONE = LW'(NUM_FRAMES);
   localparam logic [LW-1:0] FIU_RST =
      LW'((NUM_FRAMES < FIU_RESET) ? NUM_FRAMES : FIU_RESET);

   // Tag and link state, one entry per frame.
   logic                tag_valid_ff  [NUM_FRAMES];
   logic [TABLE_W-1:0]  tag_table_ff  [NUM_FRAMES];
   logic [PAGE_W-1:0]   tag_page_ff   [NUM_FRAMES];
   logic                dirty_ff      [NUM_FRAMES];
   logic                owner_ff      [NUM_FRAMES];
   logic [TRX_W-1:0]    owner_trx_ff  [NUM_FRAMES];
   logic [LW-1:0]       prev_ff       [NUM_FRAMES];
   logic [LW-1:0]       next_ff       [NUM_FRAMES];
   logic [LW-1:0]       head_ff, tail_ff;
   logic [LW-1:0]       fiu_ff;

   eng_state_type       state_ff, state_in;
   req_entry_type       req_ff;
   logic                hit_ff, hit_in;
   logic                vic_ok_ff;
   logic [LW-1:0]       f_ff, f_in;
   logic [LW-1:0]       steps_ff;
   logic                walk_stop;
   logic                out_free;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_valid_ff;

   logic                init_go;
   logic [LW-1:0]       init_fiu;
   logic [FW-1:0]       fi;
   logic [LW-1:0]       p_link, x_link;
   logic                use_f, do_head;

   // Pool setup: reset or a register write, value clamped to 1..NUM_FRAMES.
   always_comb begin
      init_go = reset || csr_valid;
      if (reset) begin
         init_fiu = FIU_RST;
      end else if (csr_data == '0) begin
         init_fiu = LW'(1);
      end else if (32'(csr_data) > 32'(NUM_FRAMES)) begin
         init_fiu = NONE;
      end else begin
         init_fiu = LW'(csr_data);
      end
   end

   // Tag match over the frames in use; the lowest matching frame wins.
   always_comb begin
      hit_in = 1'b0;
      f_in   = '0;
      for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
         if ((LW'(i) < fiu_ff) && tag_valid_ff[i] &&
             (tag_table_ff[i] == req_ff.tbl_id) &&
             (tag_page_ff[i] == req_ff.pg_no)) begin
            hit_in = 1'b1;
            f_in   = LW'(i);
         end
      end
   end

   // Victim walk stops at an unpinned frame, at a missing link or after a full lap.
   always_comb begin
      walk_stop = (f_ff >= NONE) || (steps_ff == NONE);
      if (!walk_stop) begin
         walk_stop = !owner_ff[f_ff[FW-1:0]];
      end
   end

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign fi         = f_ff[FW-1:0];
   assign p_link     = prev_ff[fi];
   assign x_link     = next_ff[fi];

   always_comb begin
      use_f   = hit_ff || ((req_ff.kind == KIND_LOAD) && vic_ok_ff);
      do_head = ((req_ff.kind == KIND_LOAD) && use_f) ||
                ((req_ff.kind == KIND_APPLY) && hit_ff);
   end

   // Sequencer: next state, queue pop and the result word.
   always_comb begin
      state_in = state_ff;
      q_pop    = 1'b0;
      rsp_in   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if ((req_ff.kind == KIND_LOAD) && !hit_in) begin
               state_in = ST_WALK;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_WALK: begin
            if (walk_stop) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (req_ff.kind != KIND_IGNORE) begin
         if (use_f) begin
            rsp_in.hit         = hit_ff;
            rsp_in.frame_valid = 1'b1;
            rsp_in.frame_index = FIDX_W'(f_ff);
            if (!hit_ff) begin
               rsp_in.fill_needed = 1'b1;
               if (tag_valid_ff[fi] && dirty_ff[fi]) begin
                  rsp_in.writeback_needed = 1'b1;
                  rsp_in.wb_tbl_id        = tag_table_ff[fi];
                  rsp_in.wb_pg_no         = tag_page_ff[fi];
               end
            end
         end else if (req_ff.kind != KIND_RELEASE) begin
            rsp_in.direct_io = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if ((state_ff == ST_DONE) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Per-request working registers.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         req_ff <= q_entry;
      end
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_ff <= rsp_in;
      end
      unique case (state_ff)
         ST_LOOK: begin
            hit_ff    <= hit_in;
            vic_ok_ff <= 1'b0;
            steps_ff  <= '0;
            f_ff      <= hit_in ? f_in : tail_ff;
         end
         ST_WALK: begin
            if (walk_stop) begin
               vic_ok_ff <= (f_ff < NONE) && !owner_ff[fi];
            end else begin
               f_ff     <= p_link;
               steps_ff <= steps_ff + LW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // Pool state: setup, or the update of one frame at the end of a request.
   always_ff @(posedge clock) begin
      if (init_go) begin
         fiu_ff  <= init_fiu;
         head_ff <= '0;
         tail_ff <= init_fiu - LW'(1);
         for (int i = 0; i < NUM_FRAMES; i++) begin
            tag_valid_ff[i] <= 1'b0;
            tag_table_ff[i] <= '0;
            tag_page_ff[i]  <= '0;
            dirty_ff[i]     <= 1'b0;
            owner_ff[i]     <= 1'b0;
            owner_trx_ff[i] <= '0;
            prev_ff[i] <= ((i > 0) && (LW'(i) < init_fiu)) ? LW'(i - 1) : NONE;
            next_ff[i] <= ((i + 1) < NUM_FRAMES + 1 && (LW'(i + 1) < init_fiu)) ?
                          LW'(i + 1) : NONE;
         end
      end else if ((state_ff == ST_DONE) && out_free && use_f) begin
         unique case (req_ff.kind)
            KIND_LOAD: begin
               if (req_ff.pin) begin
                  owner_ff[fi]     <= 1'b1;
                  owner_trx_ff[fi] <= req_ff.trx_id;
               end
               if (!hit_ff) begin
                  tag_valid_ff[fi] <= 1'b1;
                  tag_table_ff[fi] <= req_ff.tbl_id;
                  tag_page_ff[fi]  <= req_ff.pg_no;
                  dirty_ff[fi]     <= 1'b0;
               end
            end
            KIND_APPLY: begin
               dirty_ff[fi]     <= 1'b1;
               owner_ff[fi]     <= 1'b0;
               owner_trx_ff[fi] <= '0;
            end
            KIND_RELEASE: begin
               owner_ff[fi]     <= 1'b0;
               owner_trx_ff[fi] <= '0;
            end
            default: begin
            end
         endcase

         // Unlink the frame and put it at the head of the LRU list.
         if (do_head && (f_ff != head_ff) && (head_ff < NONE)) begin
            if (p_link < NONE) begin
               next_ff[p_link[FW-1:0]] <= x_link;
            end
            if (x_link < NONE) begin
               prev_ff[x_link[FW-1:0]] <= p_link;
            end
            if (f_ff == tail_ff) begin
               tail_ff <= p_link;
            end
            prev_ff[fi] <= NONE;
            next_ff[fi] <= head_ff;
            prev_ff[head_ff[FW-1:0]] <= f_ff;
            head_ff <= f_ff;
         end
      end
   end

endmodule

/* design/lru_page_buffer_pin_manager.sv */
`timescale 1ns / 1ps
// Channel   Dir  Ports                         Contents
// req       in   req_tvalid/tready/tdata/tuser page request, command in tuser
// rsp       out  rsp_tvalid/tready/tdata       lookup result
// csr       in   csr_valid/ready/data          frames_in_use, reinitializes the pool
//
// A hit or a non-load request goes from the queue through ST_LOOK and ST_DONE
// to the result register; a load miss also walks frames one by one from the
// LRU tail in ST_WALK. The engine pops a new request only from ST_IDLE, after
// the last result is registered. Reset and every csr write set up the pool.
// While a result waits for rsp_tready, the two-entry queue takes requests until full.
module lru_page_buffer_pin_manager
   import lpb_pkg::*;
#(
   parameter int NUM_FRAMES = NUM_FRAMES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // tbl_id[5:0], pg_no[37:6], trx_id[53:38], pin[54], zero fill
   input  logic [55:0]         req_tdata,
   // cmd[1:0]
   input  logic [CMD_W-1:0]    req_tuser,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // hit[0], frame_valid[1], frame_index[5:2], fill_needed[6],
   // writeback_needed[7], wb_tbl_id[13:8], wb_pg_no[45:14],
   // direct_io[46], zero fill
   output logic [47:0]         rsp_tdata,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [FIU_W-1:0]    csr_data
);

   logic          q_valid;
   logic          q_pop;
   req_entry_type q_entry;
   rsp_type       rsp_data;

   assign csr_ready = 1'b1;
   assign rsp_tdata = {1'b0, rsp_data};

   // Front: accept and classify requests into the queue.
   lpb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .q_pop      (q_pop)
   );

   // Back: lookup, victim walk and pool update.
   lpb_engine #(
      .NUM_FRAMES (NUM_FRAMES)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (rsp_data)
   );

endmodule

/* sim/lru_page_buffer_pin_manager_tb.sv */
`timescale 1ns / 1ps
module lru_page_buffer_pin_manager_tb;
   import lpb_pkg::*;

   localparam int NFR       = NUM_FRAMES_DEF;
   localparam int LINK_NULL = NFR;
   localparam int STALL_MAX = 3000;
   localparam int DRAIN_CYC = 40;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [55:0]       req_tdata = '0;
   logic [CMD_W-1:0]  req_tuser = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [47:0]       rsp_tdata;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [FIU_W-1:0]  csr_data = '0;

   lru_page_buffer_pin_manager dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the frame tags, owners and LRU links.
   int unsigned     pool_size;
   logic            sh_valid [NFR];
   logic [5:0]      sh_table [NFR];
   logic [31:0]     sh_page  [NFR];
   logic            sh_dirty [NFR];
   logic            sh_owned [NFR];
   logic [15:0]     sh_owner [NFR];
   int unsigned     sh_prev  [NFR];
   int unsigned     sh_next  [NFR];
   int unsigned     sh_head, sh_tail;

   rsp_type         lookup_q[$];
   int              errors = 0;
   int              n_hit = 0, n_fill = 0, n_wb = 0, n_direct = 0, n_items = 0;
   int              n_cfg = 0;
   bit              quiet = 1'b0;
   bit              hold_req = 1'b0;
   int              hold_cnt = 0;
   int              stall_left = 0;
   int              idle_cnt = 0;

   function automatic void pool_setup(input logic [4:0] val);
      int unsigned v;
      v = val;
      if (v < 1) v = 1;
      if (v > NFR) v = NFR;
      pool_size = v;
      for (int i = 0; i < NFR; i++) begin
         sh_valid[i] = 0; sh_table[i] = 0; sh_page[i] = 0; sh_dirty[i] = 0;
         sh_owned[i] = 0; sh_owner[i] = 0;
         sh_prev[i] = LINK_NULL; sh_next[i] = LINK_NULL;
         if (i < pool_size) begin
            if (i > 0) sh_prev[i] = i - 1;
            if (i + 1 < pool_size) sh_next[i] = i + 1;
         end
      end
      sh_head = 0;
      sh_tail = pool_size - 1;
   endfunction

   // Unlink a frame and put it at the most recently used end.
   function automatic void promote(input int unsigned f);
      int unsigned p, x;
      if (f >= NFR || f == sh_head || sh_head >= NFR) return;
      p = sh_prev[f];
      x = sh_next[f];
      if (p < NFR) sh_next[p] = x;
      if (x < NFR) sh_prev[x] = p;
      if (f == sh_tail) sh_tail = p;
      sh_prev[f] = LINK_NULL;
      sh_next[f] = sh_head;
      sh_prev[sh_head] = f;
      sh_head = f;
   endfunction

   // Compute the lookup result for one request and update the shadow pool.
   function automatic rsp_type predict_lookup(input logic [1:0] cmd,
         input logic [5:0] tbl, input logic [31:0] pg, input logic [15:0] trx,
         input logic pin);
      rsp_type     r;
      int unsigned f, steps;
      r = '0;
      f = LINK_NULL;
      for (int i = 0; i < pool_size; i++)
         if (f == LINK_NULL && sh_valid[i] && sh_table[i] == tbl && sh_page[i] == pg)
            f = i;
      if (cmd == CMD_LOAD) begin
         if (f < NFR) begin
            if (pin) begin
               sh_owned[f] = 1; sh_owner[f] = trx;
            end
            promote(f);
            r.hit = 1; r.frame_valid = 1; r.frame_index = f[3:0];
         end else begin
            // Walk from the tail to the first frame nobody holds pinned.
            f = sh_tail;
            steps = 0;
            while (f < NFR && sh_owned[f] && steps < NFR) begin
               f = sh_prev[f];
               steps++;
            end
            if (f < NFR && !sh_owned[f]) begin
               if (sh_valid[f] && sh_dirty[f]) begin
                  r.writeback_needed = 1;
                  r.wb_tbl_id = sh_table[f];
                  r.wb_pg_no  = sh_page[f];
               end
               if (pin) begin
                  sh_owned[f] = 1; sh_owner[f] = trx;
               end
               promote(f);
               sh_valid[f] = 1; sh_table[f] = tbl; sh_page[f] = pg; sh_dirty[f] = 0;
               r.frame_valid = 1; r.frame_index = f[3:0]; r.fill_needed = 1;
            end else begin
               r.direct_io = 1;
            end
         end
      end else if (cmd == CMD_APPLY) begin
         if (f < NFR) begin
            promote(f);
            sh_dirty[f] = 1; sh_owned[f] = 0; sh_owner[f] = 0;
            r.hit = 1; r.frame_valid = 1; r.frame_index = f[3:0];
         end else begin
            r.direct_io = 1;
         end
      end else if (cmd == CMD_RELEASE) begin
         if (f < NFR) begin
            sh_owned[f] = 0; sh_owner[f] = 0;
            r.hit = 1; r.frame_valid = 1; r.frame_index = f[3:0];
         end
      end
      return r;
   endfunction

   // Directed table: register writes and requests, some with typed results.
   typedef struct {
      bit          is_cfg;
      logic [4:0]  cfg_val;
      logic [1:0]  cmd;
      logic [5:0]  tbl;
      logic [31:0] pg;
      logic [15:0] trx;
      logic        pin;
      bit          typed;
      rsp_type     want;
   } dir_row_type;

   dir_row_type dir_rows[$];

   function automatic rsp_type mk(input logic hit, input logic fv, input logic [3:0] fi,
         input logic fill, input logic wb, input logic [5:0] wbt, input logic [31:0] wbp,
         input logic dio);
      rsp_type r;
      r.hit = hit; r.frame_valid = fv; r.frame_index = fi; r.fill_needed = fill;
      r.writeback_needed = wb; r.wb_tbl_id = wbt; r.wb_pg_no = wbp; r.direct_io = dio;
      return r;
   endfunction

   function automatic void add_req(input logic [1:0] cmd, input logic [5:0] tbl,
         input logic [31:0] pg, input logic [15:0] trx, input logic pin,
         input bit typed, input rsp_type want);
      dir_row_type row;
      row.is_cfg = 0; row.cfg_val = 0; row.cmd = cmd; row.tbl = tbl; row.pg = pg;
      row.trx = trx; row.pin = pin; row.typed = typed; row.want = want;
      dir_rows.push_back(row);
   endfunction

   function automatic void add_cfg(input logic [4:0] val);
      dir_row_type row;
      row = '{default: 0};
      row.is_cfg = 1; row.cfg_val = val;
      dir_rows.push_back(row);
   endfunction

   // Sender: one beat per call, random gap first unless quiet, valid held until taken.
   task automatic send_req(input logic [1:0] cmd, input logic [5:0] tbl,
         input logic [31:0] pg, input logic [15:0] trx, input logic pin,
         input bit typed, input rsp_type want);
      int      gap, r;
      rsp_type exp_r;
      @(negedge clock);
      r = $urandom_range(0, 99);
      gap = quiet ? 0 : (r < 70) ? $urandom_range(0, 1) :
            (r < 95) ? $urandom_range(2, 4) : $urandom_range(10, 30);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= {1'b0, pin, trx, pg, tbl};
      req_tuser  <= cmd;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      exp_r = predict_lookup(cmd, tbl, pg, trx, pin);
      lookup_q.push_back(typed ? want : exp_r);
      n_items++;
   endtask

   // Register write, only with the block drained.
   task automatic write_pool_size(input logic [4:0] val);
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (lookup_q.size() == 0);
      repeat (DRAIN_CYC) @(posedge clock);
      @(negedge clock);
      csr_data  <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      pool_setup(val);
      n_cfg++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Receiver: mostly ready, short and long stalls, plus a long hold on request.
   always @(negedge clock) begin
      int r;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_tready <= 1'b0;
      end else if (hold_req) begin
         hold_req = 1'b0;
         hold_cnt = 150;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (quiet) begin
         rsp_tready <= 1'b1;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            rsp_tready <= 1'b1;
         end else begin
            stall_left = (r < 97) ? $urandom_range(0, 3) : $urandom_range(10, 40);
            rsp_tready <= 1'b0;
         end
      end
   end

   // Result check against the oldest expectation.
   always @(posedge clock) begin
      rsp_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_type'(rsp_tdata[46:0]);
         if (lookup_q.size() == 0) begin
            $error("result beat with no request outstanding: %h", rsp_tdata);
            errors++;
         end else begin
            want = lookup_q.pop_front();
            if (got.hit !== want.hit) begin
               $error("hit: expected %0d, got %0d", want.hit, got.hit); errors++;
            end
            if (got.frame_valid !== want.frame_valid) begin
               $error("frame_valid: expected %0d, got %0d", want.frame_valid,
                      got.frame_valid); errors++;
            end
            if (got.frame_index !== want.frame_index) begin
               $error("frame_index: expected %0d, got %0d", want.frame_index,
                      got.frame_index); errors++;
            end
            if (got.fill_needed !== want.fill_needed) begin
               $error("fill_needed: expected %0d, got %0d", want.fill_needed,
                      got.fill_needed); errors++;
            end
            if (got.writeback_needed !== want.writeback_needed) begin
               $error("writeback_needed: expected %0d, got %0d", want.writeback_needed,
                      got.writeback_needed); errors++;
            end
            if (got.wb_tbl_id !== want.wb_tbl_id) begin
               $error("wb_tbl_id: expected %0d, got %0d", want.wb_tbl_id,
                      got.wb_tbl_id); errors++;
            end
            if (got.wb_pg_no !== want.wb_pg_no) begin
               $error("wb_pg_no: expected %h, got %h", want.wb_pg_no,
                      got.wb_pg_no); errors++;
            end
            if (got.direct_io !== want.direct_io) begin
               $error("direct_io: expected %0d, got %0d", want.direct_io,
                      got.direct_io); errors++;
            end
            n_hit += want.hit; n_fill += want.fill_needed;
            n_wb += want.writeback_needed; n_direct += want.direct_io;
         end
      end
   end

   // Watchdog on cycles without any accepted beat.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cnt <= 0;
      end else if (idle_cnt >= STALL_MAX) begin
         $display("timeout: no beat accepted for %0d cycles", STALL_MAX);
         $display("FAIL lru_page_buffer_pin_manager");
         $finish;
      end else begin
         idle_cnt <= idle_cnt + 1;
      end
   end

   // Stimulus.
   initial begin
      logic [5:0]  key_tbl[24];
      logic [31:0] key_pg[24];
      logic [4:0]  phase_vals[7];
      rsp_type     none;
      int          nkeys, k, r;
      logic [1:0]  cmd;

      none = '0;
      pool_setup(5'(FIU_RESET));
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Fresh pool of 16: first miss takes the tail frame.
      add_req(CMD_LOAD, 6'd63, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1, mk(0, 1, 15, 1, 0, 0, 0, 0));
      add_req(CMD_LOAD, 6'd63, 32'hFFFF_FFFF, 16'h0000, 1'b0, 1, mk(1, 1, 15, 0, 0, 0, 0, 0));
      add_req(CMD_LOAD, 6'd0, 32'h0, 16'd1, 1'b1, 1, mk(0, 1, 14, 1, 0, 0, 0, 0));
      // Pin by another transaction takes over ownership.
      add_req(CMD_LOAD, 6'd0, 32'h0, 16'd2, 1'b1, 1, mk(1, 1, 14, 0, 0, 0, 0, 0));
      add_req(CMD_APPLY, 6'd0, 32'h0, 16'd2, 1'b0, 1, mk(1, 1, 14, 0, 0, 0, 0, 0));
      add_req(CMD_NOP, 6'd63, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1, none);
      add_req(CMD_RELEASE, 6'd5, 32'd5, 16'd5, 1'b0, 1, none);
      add_req(CMD_APPLY, 6'd5, 32'd5, 16'd5, 1'b0, 1, mk(0, 0, 0, 0, 0, 0, 0, 1));
      add_req(CMD_RELEASE, 6'd63, 32'hFFFF_FFFF, 16'd9, 1'b1, 1, mk(1, 1, 15, 0, 0, 0, 0, 0));
      add_req(CMD_LOAD, 6'd21, 32'hA5A5_A5A5, 16'h5A5A, 1'b0, 0, none);
      add_req(CMD_LOAD, 6'd42, 32'h5A5A_5A5A, 16'hA5A5, 1'b1, 0, none);
      // Single frame: all pinned, dirty eviction, clean eviction.
      add_cfg(5'd0);
      add_req(CMD_LOAD, 6'd3, 32'd3, 16'd7, 1'b1, 1, mk(0, 1, 0, 1, 0, 0, 0, 0));
      add_req(CMD_LOAD, 6'd4, 32'd4, 16'd8, 1'b1, 1, mk(0, 0, 0, 0, 0, 0, 0, 1));
      add_req(CMD_APPLY, 6'd3, 32'd3, 16'd7, 1'b0, 1, mk(1, 1, 0, 0, 0, 0, 0, 0));
      add_req(CMD_LOAD, 6'd4, 32'd4, 16'd8, 1'b0, 1, mk(0, 1, 0, 1, 1, 3, 3, 0));
      add_req(CMD_RELEASE, 6'd4, 32'd4, 16'd8, 1'b0, 1, mk(1, 1, 0, 0, 0, 0, 0, 0));
      add_req(CMD_LOAD, 6'd3, 32'd3, 16'd7, 1'b0, 1, mk(0, 1, 0, 1, 0, 0, 0, 0));
      add_cfg(5'd31);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_cfg)
            write_pool_size(dir_rows[i].cfg_val);
         else
            send_req(dir_rows[i].cmd, dir_rows[i].tbl, dir_rows[i].pg, dir_rows[i].trx,
                     dir_rows[i].pin, dir_rows[i].typed, dir_rows[i].want);
      end

      // Pages drawn from a small set so that hits and evictions are frequent.
      for (int i = 0; i < 24; i++) begin
         key_tbl[i] = 6'($urandom);
         key_pg[i]  = $urandom;
      end
      key_tbl[0] = 6'd0;  key_pg[0] = 32'h0;
      key_tbl[1] = 6'd63; key_pg[1] = 32'hFFFF_FFFF;

      phase_vals = '{5'd16, 5'd2, 5'd0, 5'd5, 5'd31, 5'd8, 5'd16};
      foreach (phase_vals[p]) begin
         write_pool_size(phase_vals[p]);
         quiet = (p == 3);
         if (p == 6) hold_req = 1'b1;
         nkeys = (pool_size + 4 > 24) ? 24 : pool_size + 4;
         for (int n = 0; n < 75; n++) begin
            k = $urandom_range(0, nkeys - 1);
            r = $urandom_range(0, 99);
            cmd = (r < 50) ? CMD_LOAD : (r < 72) ? CMD_APPLY :
                  (r < 92) ? CMD_RELEASE : CMD_NOP;
            send_req(cmd, key_tbl[k], key_pg[k], 16'($urandom), 1'($urandom), 0, none);
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (lookup_q.size() == 0);
      repeat (DRAIN_CYC) @(posedge clock);

      $display("Covered %0d requests over %0d pool-size writes: %0d hits, %0d fills,",
               n_items, n_cfg, n_hit, n_fill);
      $display("%0d dirty writebacks, %0d direct I/O results; %0d mismatches.",
               n_wb, n_direct, errors);
      if (errors == 0)
         $display("PASS lru_page_buffer_pin_manager");
      else
         $display("FAIL lru_page_buffer_pin_manager");
      $finish;
   end

endmodule
